// ===== rtl/periodic_timing_wheel_defines.svh =====
// assertion macros shared by the periodic timing wheel rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef PERIODIC_TIMING_WHEEL_DEFINES_SVH
`define PERIODIC_TIMING_WHEEL_DEFINES_SVH

// condition holds on every clock edge out of reset
`define PTW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PTW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define PTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptw_pkg.sv =====
// shared types and constants of the periodic timing wheel
// no dependencies
`default_nettype none

package ptw_pkg;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 4;
    localparam int PERIOD_W = 16;
    localparam int KIND_W   = 2;
    localparam int ID_SPACE = 16;

    // parameter defaults
    localparam int WHEEL_SLOTS_DEF = 8;
    localparam int MAX_TIMERS_DEF  = 16;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_REG   = 2'd0,
        CMD_UNREG = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_REG   = 2'd0,
        KIND_REJ   = 2'd1,
        KIND_UNREG = 2'd2,
        KIND_FIRE  = 2'd3
    } t_kind;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RESP,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // write / clear request broadcast to the cell chain
    typedef struct packed {
        logic            wr;
        logic            clr;
        logic [ID_W-1:0] id;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/ptw_cmd_if.sv =====
// input channel of the periodic timing wheel: valid/ready plus command beat
// depends on ptw_pkg
`default_nettype none

interface ptw_cmd_if;
    import ptw_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     timer_id;
    logic [PERIOD_W-1:0] period;

    modport source (output valid, output cmd, output timer_id, output period, input ready);
    modport sink   (input valid, input cmd, input timer_id, input period, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptw_res_if.sv =====
// result channel of the periodic timing wheel: valid/ready plus result beat
// depends on ptw_pkg
`default_nettype none

interface ptw_res_if;
    import ptw_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   timer_id_res;
    logic              last;

    modport source (output valid, output kind, output timer_id_res, output last, input ready);
    modport sink   (input valid, input kind, input timer_id_res, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptw_div.sv =====
// two-stage divider by the constant slot count: reciprocal multiply, then remainder
// depends on ptw_pkg
`default_nettype none

module ptw_div #(
    parameter int WHEEL_SLOTS = ptw_pkg::WHEEL_SLOTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [ptw_pkg::PERIOD_W-1:0]      i_dividend,
    output logic                                   o_done,
    output logic [ptw_pkg::PERIOD_W-1:0]           o_quo,
    output logic [$clog2(WHEEL_SLOTS)-1:0]         o_rem
);
    import ptw_pkg::*;

    localparam int SW    = $clog2(WHEEL_SLOTS);
    // floor(x * MULT / 2^SHIFT) is floor(x / slots) for every x of PERIOD_W bits
    localparam int SHIFT = PERIOD_W + SW;
    localparam int MW    = PERIOD_W + 1;
    localparam int PW    = PERIOD_W + MW;
    localparam int MULT  = ((1 << SHIFT) + WHEEL_SLOTS - 1) / WHEEL_SLOTS;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [PERIOD_W-1:0] r_num, n_num;
    logic [PERIOD_W-1:0] r_quo, n_quo;
    logic [SW-1:0]       r_rem, n_rem;

    logic [PW-1:0]       w_prod;
    logic [PERIOD_W-1:0] w_back;

    // stage one: quotient by reciprocal multiplication
    assign w_prod = PW'(i_dividend) * PW'(MULT);

    // stage two: quotient times slot count, never above the dividend
    assign w_back = r_quo * PERIOD_W'(WHEEL_SLOTS);

    always_comb begin
        n_busy = 1'b0;
        n_done = 1'b0;
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_num  = i_dividend;
            n_quo  = PERIOD_W'(w_prod >> SHIFT);
        end else if (r_busy) begin
            n_done = 1'b1;
            n_rem  = SW'(r_num - w_back);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/ptw_cell.sv =====
// one timer entry of the wheel; a scan token passes through it to the next cell
// depends on ptw_pkg
`default_nettype none

module ptw_cell #(
    parameter int WHEEL_SLOTS = ptw_pkg::WHEEL_SLOTS_DEF,
    parameter int CELL_IDX    = 0,
    parameter int RW          = 13
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ptw_pkg::t_cell_ctl           i_ctl,
    input  wire logic [$clog2(WHEEL_SLOTS)-1:0] i_cur,
    input  wire logic [$clog2(WHEEL_SLOTS)-1:0] i_mod,
    input  wire logic [RW-1:0]                i_rounds0,
    input  wire logic                         i_tok,
    output logic                              o_tok,
    output logic                              o_fire
);
    import ptw_pkg::*;

    localparam int SW = $clog2(WHEEL_SLOTS);

    logic          r_valid, n_valid;
    logic          r_tok;
    logic [SW-1:0] r_slot, n_slot;
    logic [SW-1:0] r_mod, n_mod;
    logic [RW-1:0] r_rounds0, n_rounds0;
    logic [RW-1:0] r_rounds, n_rounds;

    logic          w_match, w_hit, w_fire;
    logic [SW-1:0] w_mod_src;
    logic [SW:0]   w_sum;
    logic [SW-1:0] w_next_slot;

    // entry selection and scan hit
    assign w_match = (i_ctl.id == ID_W'(CELL_IDX));
    assign w_hit   = r_tok && r_valid && (r_slot == i_cur);
    assign w_fire  = w_hit && (r_rounds == '0);

    // slot of the next expiry: current slot plus period mod slots
    assign w_mod_src   = (i_ctl.wr && w_match) ? i_mod : r_mod;
    assign w_sum       = {1'b0, i_cur} + {1'b0, w_mod_src};
    assign w_next_slot = (w_sum >= (SW+1)'(WHEEL_SLOTS)) ?
                         SW'(w_sum - (SW+1)'(WHEEL_SLOTS)) : w_sum[SW-1:0];

    // entry update
    always_comb begin
        n_valid   = r_valid;
        n_slot    = r_slot;
        n_mod     = r_mod;
        n_rounds0 = r_rounds0;
        n_rounds  = r_rounds;
        priority if (i_ctl.wr && w_match) begin
            n_valid   = 1'b1;
            n_mod     = i_mod;
            n_rounds0 = i_rounds0;
            n_slot    = w_next_slot;
            n_rounds  = i_rounds0;
        end else if (i_ctl.clr && w_match) begin
            n_valid = 1'b0;
        end else if (w_fire) begin
            n_slot   = w_next_slot;
            n_rounds = r_rounds0;
        end else if (w_hit) begin
            n_rounds = r_rounds - RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= i_tok;
        end
        r_slot    <= n_slot;
        r_mod     <= n_mod;
        r_rounds0 <= n_rounds0;
        r_rounds  <= n_rounds;
    end

    assign o_tok  = r_tok;
    assign o_fire = w_fire;

endmodule

`default_nettype wire

// ===== rtl/periodic_timing_wheel.sv =====
// Periodic timing wheel: a row of timer cells swept by a scan token, one cell a
// cycle, plus a two-stage reciprocal divider for the slot and round split of a period.
// A register beat passes through the divider, which splits period-1 into rounds and slot
// offset, then writes the cell and loads the result before the next beat can enter; a
// rejected register or an unregister beat goes straight to the result. A tick beat
// sweeps the token through every timer cell (16 by default), then reports each expired
// timer, or returns to idle when nothing expires. A result that waits for ready holds
// the controller in its response or emit state. The result register lets the next
// command enter while a result still waits to be taken. Expirations come out in
// ascending id order, the final one with last set; a tick with no expiry gives no result.
// Depends on ptw_pkg, ptw_cmd_if, ptw_res_if, ptw_div, ptw_cell.
`default_nettype none
`include "periodic_timing_wheel_defines.svh"

module periodic_timing_wheel #(
    parameter int WHEEL_SLOTS = ptw_pkg::WHEEL_SLOTS_DEF,
    parameter int MAX_TIMERS  = ptw_pkg::MAX_TIMERS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ptw_cmd_if.sink    i_cmd,
    ptw_res_if.source  o_res
);
    import ptw_pkg::*;

    localparam int SW    = $clog2(WHEEL_SLOTS);
    localparam int RW    = $clog2(((1 << PERIOD_W) - 1) / WHEEL_SLOTS + 1);
    localparam int NCELL = (MAX_TIMERS < ID_SPACE) ? MAX_TIMERS : ID_SPACE;

    t_state              r_state, n_state;
    logic [SW-1:0]       r_cur;
    logic [ID_W-1:0]     r_id;
    t_kind               r_kind;
    logic [NCELL-1:0]    r_fire_mask;
    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [ID_W-1:0]     r_out_id;
    logic                r_out_last;

    logic                w_in_beat, w_in_ready, w_reject, w_out_free, w_out_load;
    logic                w_div_start, w_div_done, w_tok_start;
    t_cmd                w_cmd;
    t_cell_ctl           w_ctl;
    logic [PERIOD_W-1:0] w_div_quo;
    logic [SW-1:0]       w_div_rem, w_mod;
    logic [RW-1:0]       w_rounds0;
    logic [NCELL-1:0]    w_tok_vec, w_fire_vec, w_mask_rest;
    logic [NCELL:0]      w_tok_chain;
    logic [ID_W-1:0]     w_low_idx;

    // handshake and decode
    assign w_cmd      = t_cmd'(i_cmd.cmd);
    assign w_in_beat  = i_cmd.valid && w_in_ready;
    assign w_reject   = (i_cmd.period == '0) || (int'(i_cmd.timer_id) >= MAX_TIMERS);
    assign w_out_free = !r_out_valid || o_res.ready;

    // divider for rounds and slot offset of a new period
    ptw_div #(.WHEEL_SLOTS(WHEEL_SLOTS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_cmd.period - PERIOD_W'(1)),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    // period mod slots is remainder of period-1 plus one, wrapped
    assign w_mod     = (w_div_rem == SW'(WHEEL_SLOTS - 1)) ? '0 : w_div_rem + SW'(1);
    assign w_rounds0 = w_div_quo[RW-1:0];

    // cell chain with the scan token
    assign w_tok_chain[0] = w_tok_start;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        ptw_cell #(
            .WHEEL_SLOTS (WHEEL_SLOTS),
            .CELL_IDX    (g),
            .RW          (RW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_cur     (r_cur),
            .i_mod     (w_mod),
            .i_rounds0 (w_rounds0),
            .i_tok     (w_tok_chain[g]),
            .o_tok     (w_tok_chain[g+1]),
            .o_fire    (w_fire_vec[g])
        );
    end

    assign w_tok_vec = w_tok_chain[NCELL:1];

    // lowest pending expiry
    always_comb begin
        w_low_idx = '0;
        for (int k = NCELL - 1; k >= 0; k--) begin
            if (r_fire_mask[k]) begin
                w_low_idx = ID_W'(k);
            end
        end
    end

    assign w_mask_rest = r_fire_mask & ~(NCELL'(1) << w_low_idx);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_beat) begin
                    unique case (w_cmd)
                        CMD_REG:   n_state = w_reject ? ST_RESP : ST_DIV;
                        CMD_UNREG: n_state = ST_RESP;
                        CMD_TICK:  n_state = ST_SCAN;
                        CMD_NONE:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIV: begin
                if (w_div_done) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (w_tok_vec[NCELL-1]) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_fire_mask == '0) begin
                    n_state = ST_IDLE;
                end else if (w_out_free && (w_mask_rest == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        w_in_ready  = (r_state == ST_IDLE);
        w_div_start = 1'b0;
        w_tok_start = 1'b0;
        w_ctl.wr    = 1'b0;
        w_ctl.clr   = 1'b0;
        w_ctl.id    = r_id;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_ctl.id    = i_cmd.timer_id;
                w_div_start = w_in_beat && (w_cmd == CMD_REG) && !w_reject;
                w_tok_start = w_in_beat && (w_cmd == CMD_TICK);
                w_ctl.clr   = w_in_beat && (w_cmd == CMD_UNREG);
            end
            ST_DIV:  w_ctl.wr   = w_div_done;
            ST_RESP: w_out_load = w_out_free;
            ST_SCAN: w_out_load = 1'b0;
            ST_EMIT: w_out_load = w_out_free && (r_fire_mask != '0);
            default: w_out_load = 1'b0;
        endcase
    end

    // state, wheel pointer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_fire_mask <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_tok_start) begin
                r_cur <= (r_cur == SW'(WHEEL_SLOTS - 1)) ? '0 : r_cur + SW'(1);
            end
            if (r_state == ST_SCAN) begin
                r_fire_mask <= r_fire_mask | w_fire_vec;
            end else if (r_state == ST_EMIT && w_out_load) begin
                r_fire_mask <= w_mask_rest;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_beat) begin
            r_id   <= i_cmd.timer_id;
            r_kind <= (w_cmd == CMD_UNREG) ? KIND_UNREG : (w_reject ? KIND_REJ : KIND_REG);
        end
        if (w_out_load) begin
            if (r_state == ST_EMIT) begin
                r_out_kind <= KIND_FIRE;
                r_out_id   <= w_low_idx;
                r_out_last <= (w_mask_rest == '0);
            end else begin
                r_out_kind <= r_kind;
                r_out_id   <= r_id;
                r_out_last <= 1'b1;
            end
        end
    end

    // ports
    assign i_cmd.ready        = w_in_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out_kind;
    assign o_res.timer_id_res = r_out_id;
    assign o_res.last         = r_out_last;

    // checks
    `PTW_ASSERT_ALWAYS(a_tok_single, $onehot0(w_tok_vec), "more than one scan token in the chain")
    `PTW_ASSERT_IMPL(a_idle_mask_empty, r_state == ST_IDLE, r_fire_mask == '0,
        "pending expiries left behind in idle")
    `PTW_ASSERT_IMPL(a_div_done_in_div, r_state != ST_DIV, !w_div_done,
        "divider finished outside of a register command")
    `PTW_ASSERT_NEXT(a_cmd_leaves_idle, w_in_beat && (w_cmd != CMD_NONE), r_state != ST_IDLE,
        "accepted command did not start work")

endmodule

`default_nettype wire
